/* sv/mpic_pkg.sv */
`default_nettype none

package mpic_pkg;

    typedef logic [2:0] mode_t;

    localparam mode_t MODE_SET        = 3'd0;
    localparam mode_t MODE_CLEAR      = 3'd1;
    localparam mode_t MODE_CLEAR_ALL  = 3'd2;
    localparam mode_t MODE_WRITE_NCH  = 3'd3;
    localparam mode_t MODE_READ_NCH   = 3'd4;
    localparam mode_t MODE_RECOMPUTE  = 3'd5;
    localparam mode_t MODE_SERVE      = 3'd6;

    localparam int NUM_GROUPS = 10;

    localparam logic [31:0] ALWAYS_ON_MASK = 32'h8000_0000;
    localparam logic [31:0] NCHAN_KEEP     = 32'h000F_FFF0;

    localparam logic [31:0] GROUP_MASK [NUM_GROUPS] = '{
        32'h4000_0000,
        32'h2000_0000,
        32'h1000_0000,
        32'h0800_0000,
        32'h07F0_0000,
        32'h000C_0000,
        32'h0003_0000,
        32'h0000_FC00,
        32'h0000_03F0,
        32'h0000_000F
    };

    typedef struct packed {
        logic [31:0] request;
        logic [31:0] pending;
        logic [15:0] read_value;
        logic        served_valid;
        logic [4:0]  served_line;
    } mpic_upd_t;

    function automatic logic [31:0] enable_mask(input logic [15:0] status);
        logic [31:0] m;
        m = ALWAYS_ON_MASK;
        for (int k = 0; k < NUM_GROUPS; k++) begin
            if (status[15 - k]) begin
                m = m | GROUP_MASK[k];
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] line_bit(input logic [4:0] line);
        logic [31:0] m;
        m = '0;
        m[5'd31 - line] = 1'b1;
        return m;
    endfunction

    // Leading-zero count in five halving steps; it equals the line number
    // of the highest-priority set bit.
    function automatic logic [4:0] first_line(input logic [31:0] v);
        logic [31:0] w;
        logic [4:0]  n;
        w = v;
        n = '0;
        if (w[31:16] == 16'h0) begin
            n[4] = 1'b1;
            w = w << 16;
        end
        if (w[31:24] == 8'h0) begin
            n[3] = 1'b1;
            w = w << 8;
        end
        if (w[31:28] == 4'h0) begin
            n[2] = 1'b1;
            w = w << 4;
        end
        if (w[31:30] == 2'h0) begin
            n[1] = 1'b1;
            w = w << 2;
        end
        if (!w[31]) begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* sv/mpic_if.sv */
`default_nettype none

interface mpic_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [4:0]  line;
    logic [15:0] write_value;
    logic [15:0] status_word;

    modport source (output valid, output mode, output line, output write_value,
                    output status_word, input ready);
    modport sink (input valid, input mode, input line, input write_value,
                  input status_word, output ready);
endinterface

interface mpic_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_value;
    logic [31:0] pending_vector;
    logic        any_pending;
    logic        served_valid;
    logic [4:0]  served_line;

    modport source (output valid, output read_value, output pending_vector,
                    output any_pending, output served_valid, output served_line,
                    input ready);
    modport sink (input valid, input read_value, input pending_vector,
                  input any_pending, input served_valid, input served_line,
                  output ready);
endinterface

`default_nettype wire

/* sv/mpic_next.sv */
`default_nettype none

module mpic_next
    import mpic_pkg::*;
(
    input  wire logic [31:0] request,
    input  wire logic [31:0] pending,
    input  wire mode_t       mode,
    input  wire logic [4:0]  line,
    input  wire logic [15:0] write_value,
    input  wire logic [15:0] status_word,
    output mpic_upd_t        upd
);

    logic [31:0] mask;
    logic [31:0] lbit;
    logic [31:0] nch_request;
    logic [4:0]  first;
    logic [31:0] first_bit;

    assign mask        = enable_mask(status_word);
    assign lbit        = line_bit(line);
    assign nch_request = (request & NCHAN_KEEP)
                       | {write_value[15:4], 20'h0_0000}
                       | {28'h000_0000, write_value[3:0]};
    assign first       = first_line(pending);
    assign first_bit   = line_bit(first);

    always_comb
    begin
        upd.request      = request;
        upd.pending      = pending;
        upd.read_value   = '0;
        upd.served_valid = 1'b0;
        upd.served_line  = '0;
        unique case (mode)
            MODE_SET:
            begin
                upd.request = request | lbit;
                upd.pending = (request | lbit) & mask;
            end
            MODE_CLEAR:
            begin
                upd.request = request & ~lbit;
                upd.pending = pending & ~lbit;
            end
            MODE_CLEAR_ALL:
            begin
                upd.request = '0;
                upd.pending = '0;
            end
            MODE_WRITE_NCH:
            begin
                upd.request = nch_request;
                upd.pending = nch_request & mask;
            end
            MODE_READ_NCH:
            begin
                upd.read_value = {request[31:20], request[3:0]};
            end
            MODE_RECOMPUTE:
            begin
                upd.pending = request & mask;
            end
            MODE_SERVE:
            begin
                if (pending != 32'h0) begin
                    upd.served_valid = 1'b1;
                    upd.served_line  = first;
                    upd.request      = request & ~first_bit;
                    upd.pending      = pending & ~first_bit;
                end
            end
            default:
            begin
                upd.request = request;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/masked_priority_interrupt_controller.sv */
// Masked priority interrupt controller with 32 request lines.
// Input channel req carries one command transaction: mode, line, write_value
// and the current status_word, whose bits 15..6 select the enabled groups.
// Output channel rsp returns exactly one result transaction per command:
// read_value, the pending register after the command, any_pending and, for
// serve, the chosen line number with served_valid.
// The result is registered: a command accepted at a clock edge has its result
// on rsp right after that edge.
// Throughput is one command per cycle while rsp is not stalled; the
// request/pending update and the 32-bit priority encode are combinational
// logic between the state registers and the result register.
// When the receiver stalls, the result register holds its transaction and
// req.ready stays high only if that result is taken in the same cycle, so
// nothing is lost and at most one result waits.
// Reset clears the request and pending registers and drops rsp.valid; the
// block accepts commands as soon as reset is released.
`default_nettype none

module masked_priority_interrupt_controller
    import mpic_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mpic_in_if.sink     req,
    mpic_out_if.source  rsp
);

    logic [31:0] request_reg;
    logic [31:0] pending_reg;
    logic        rsp_valid_reg;
    logic [15:0] read_value_reg;
    logic        served_valid_reg;
    logic [4:0]  served_line_reg;
    logic        accept;
    mpic_upd_t   upd;

    mpic_next u_next (
        .request     (request_reg),
        .pending     (pending_reg),
        .mode        (req.mode),
        .line        (req.line),
        .write_value (req.write_value),
        .status_word (req.status_word),
        .upd         (upd)
    );

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            request_reg   <= '0;
            pending_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                request_reg   <= upd.request;
                pending_reg   <= upd.pending;
                rsp_valid_reg <= 1'b1;
            end else if (rsp.ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            read_value_reg   <= upd.read_value;
            served_valid_reg <= upd.served_valid;
            served_line_reg  <= upd.served_line;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.read_value     = read_value_reg;
    assign rsp.pending_vector = pending_reg;
    assign rsp.any_pending    = pending_reg != 32'h0;
    assign rsp.served_valid   = served_valid_reg;
    assign rsp.served_line    = served_line_reg;

endmodule

`default_nettype wire

/* sv/mpic_checker.sv */
`default_nettype none

module mpic_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] pending_vector,
    input wire logic        any_pending,
    input wire logic        served_valid,
    input wire logic [4:0]  served_line
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp transaction dropped while stalled");

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted command produced no result");

    a_any_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (any_pending == (pending_vector != 32'h0)))
        else $error("any_pending disagrees with pending_vector");

    a_served_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && served_valid |-> !pending_vector[5'd31 - served_line])
        else $error("served line still pending");

endmodule

bind masked_priority_interrupt_controller mpic_checker u_mpic_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .pending_vector (rsp.pending_vector),
    .any_pending    (rsp.any_pending),
    .served_valid   (rsp.served_valid),
    .served_line    (rsp.served_line)
);

`default_nettype wire
